FILE: rtl/tree_plru_set_assoc_tag_array_assert.svh
`ifndef TREE_PLRU_SET_ASSOC_TAG_ARRAY_ASSERT_SVH
`define TREE_PLRU_SET_ASSOC_TAG_ARRAY_ASSERT_SVH

// same-cycle implication, ignored while reset is asserted
`define TPSA_ASSERT_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("tpsa check failed");

// next-cycle implication, also checked during reset
`define TPSA_ASSERT_NXT(lbl, clk, a, b) \
    lbl: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("tpsa check failed");

`endif

FILE: rtl/tpsa_pkg.sv
package tpsa_pkg;

    localparam int SETS      = 64;
    localparam int WAYS      = 8;
    localparam int ADDR_BITS = 32;

    localparam int LVL   = $clog2(WAYS);
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int TAG_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;

    typedef enum logic [1:0] {
        CMD_LOOKUP     = 2'd0,
        CMD_FILL       = 2'd1,
        CMD_INVALIDATE = 2'd2,
        CMD_MARK_DIRTY = 2'd3
    } t_cmd;

    typedef logic [WAYS-2:0]  t_plru;
    typedef logic [LVL-1:0]   t_way;
    typedef logic [SET_W-1:0] t_set;
    typedef logic [WAYS-1:0][TAG_W-1:0] t_tag_row;

    typedef struct packed {
        logic [WAYS-1:0] valid;
        logic [WAYS-1:0] dirty;
        t_plru           plru;
    } t_state_row;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] blk_addr;
        logic        wr_req;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic        victim_valid;
        logic [31:0] victim_addr;
        logic        victim_dirty;
        logic        found_dirty;
    } t_out;

    // point every node on the path away from way w (heap order, 1 = right)
    function automatic t_plru plru_touch(input t_plru t, input t_way w);
        t_plru r;
        t_way  node;
        r    = t;
        node = '0;
        for (int l = 0; l < LVL; l++) begin
            if (!w[LVL-1-l]) begin
                r[node] = 1'b1;
                node    = t_way'(2 * node + 1);
            end else begin
                r[node] = 1'b0;
                node    = t_way'(2 * node + 2);
            end
        end
        return r;
    endfunction

    // follow the tree bits down to a leaf
    function automatic t_way plru_victim(input t_plru t);
        t_way v;
        t_way node;
        v    = '0;
        node = '0;
        for (int l = 0; l < LVL; l++) begin
            v[LVL-1-l] = t[node];
            node       = t[node] ? t_way'(2 * node + 2) : t_way'(2 * node + 1);
        end
        return v;
    endfunction

    function automatic t_set set_of(input logic [31:0] a);
        return t_set'(a) & t_set'(SETS - 1);
    endfunction

endpackage

FILE: rtl/tree_plru_set_assoc_tag_array.sv
// Tag and state array for one set-associative cache level with tree pseudo-LRU
// replacement. Takes one command beat per cycle while the output side is not
// stalled (lookup, fill, invalidate, mark dirty) and returns exactly one
// registered result beat per command. The set row (all tags, valid/dirty bits
// and tree bits) is read from memory at the accept edge and written back as the
// command leaves stage 1; a one-row forward register covers a command that hits
// the same set as the command just before it. Per-row init flops cleared by
// reset make never-written rows read as empty, so there is no clearing pass and
// commands are taken right after reset.
module tree_plru_set_assoc_tag_array (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tpsa_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tpsa_pkg::t_out o_out_data
);

    tpsa_pkg::t_tag_row   mem_tag   [tpsa_pkg::SETS];
    tpsa_pkg::t_state_row mem_state [tpsa_pkg::SETS];
    logic [tpsa_pkg::SETS-1:0] r_init;

    logic                 r_s1_vld;
    tpsa_pkg::t_in        r_s1;
    tpsa_pkg::t_tag_row   r_rd_tags;
    tpsa_pkg::t_state_row r_rd_state;
    logic                 r_rd_init;

    logic                 r_fwd_vld;
    tpsa_pkg::t_set       r_fwd_set;
    tpsa_pkg::t_tag_row   r_fwd_tags;
    tpsa_pkg::t_state_row r_fwd_state;

    logic                 r_out_vld;
    tpsa_pkg::t_out       r_out_data;

    logic                 in_acc;
    logic                 s1_adv;
    tpsa_pkg::t_set       in_set;
    tpsa_pkg::t_set       s1_set;
    logic [tpsa_pkg::TAG_W-1:0] s1_tag;
    logic                 fwd_hit;
    tpsa_pkg::t_tag_row   cur_tags;
    tpsa_pkg::t_state_row cur_state;
    logic [tpsa_pkg::WAYS-1:0] match;
    logic                 any_match;
    tpsa_pkg::t_way       match_way;
    logic                 any_free;
    tpsa_pkg::t_way       free_way;
    tpsa_pkg::t_way       fill_way;

    tpsa_pkg::t_tag_row   n_tags;
    tpsa_pkg::t_state_row n_state;
    tpsa_pkg::t_out       n_out;

    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_set     = tpsa_pkg::set_of(i_in_data.blk_addr);
    assign s1_set     = tpsa_pkg::set_of(r_s1.blk_addr);
    assign s1_tag     = tpsa_pkg::TAG_W'(r_s1.blk_addr);

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // row written at the last edge is not yet visible in the read data
    assign fwd_hit   = r_fwd_vld && (r_fwd_set == s1_set);
    assign cur_tags  = fwd_hit ? r_fwd_tags : r_rd_tags;
    assign cur_state = fwd_hit ? r_fwd_state : (r_rd_init ? r_rd_state : '0);

    always_comb begin
        any_match = 1'b0;
        match_way = '0;
        any_free  = 1'b0;
        free_way  = '0;
        for (int w = 0; w < tpsa_pkg::WAYS; w++) begin
            match[w] = cur_state.valid[w] && (cur_tags[w] == s1_tag);
        end
        for (int w = tpsa_pkg::WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                any_match = 1'b1;
                match_way = tpsa_pkg::t_way'(w);
            end
            if (!cur_state.valid[w]) begin
                any_free = 1'b1;
                free_way = tpsa_pkg::t_way'(w);
            end
        end
        fill_way = any_free ? free_way : tpsa_pkg::plru_victim(cur_state.plru);
    end

    always_comb begin
        n_tags  = cur_tags;
        n_state = cur_state;
        n_out   = '0;
        case (r_s1.cmd)
            tpsa_pkg::CMD_LOOKUP: begin
                if (any_match) begin
                    n_out.hit = 1'b1;
                    if (r_s1.wr_req) begin
                        n_state.dirty[match_way] = 1'b1;
                    end
                    n_state.plru = tpsa_pkg::plru_touch(cur_state.plru, match_way);
                end
            end
            tpsa_pkg::CMD_FILL: begin
                if (cur_state.valid[fill_way]) begin
                    n_out.victim_valid = 1'b1;
                    n_out.victim_addr  = 32'(cur_tags[fill_way]);
                    n_out.victim_dirty = cur_state.dirty[fill_way];
                end
                n_tags[fill_way]        = s1_tag;
                n_state.valid[fill_way] = 1'b1;
                n_state.dirty[fill_way] = r_s1.wr_req;
                n_state.plru = tpsa_pkg::plru_touch(cur_state.plru, fill_way);
            end
            tpsa_pkg::CMD_INVALIDATE: begin
                if (any_match) begin
                    n_out.hit                = 1'b1;
                    n_out.found_dirty        = cur_state.dirty[match_way];
                    n_state.valid[match_way] = 1'b0;
                end
            end
            tpsa_pkg::CMD_MARK_DIRTY: begin
                if (any_match) begin
                    n_out.hit                = 1'b1;
                    n_state.dirty[match_way] = 1'b1;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_tags  <= mem_tag[in_set];
            r_rd_state <= mem_state[in_set];
        end
        if (s1_adv) begin
            mem_tag[s1_set]   <= n_tags;
            mem_state[s1_set] <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_rd_init <= 1'b0;
        end else begin
            if (in_acc) begin
                r_rd_init <= r_init[in_set];
            end
            if (s1_adv) begin
                r_init[s1_set] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_fwd_vld <= 1'b1;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in_data;
        end
        if (s1_adv) begin
            r_fwd_set   <= s1_set;
            r_fwd_tags  <= n_tags;
            r_fwd_state <= n_state;
            r_out_data  <= n_out;
        end
    end

endmodule

FILE: rtl/tpsa_checker.sv
`include "tree_plru_set_assoc_tag_array_assert.svh"

module tpsa_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input tpsa_pkg::t_out o_out_data
);

    // a result beat is either a fill report or a match report, never both
    `TPSA_ASSERT_IMP(a_fill_excl, i_clk, i_rst_n,
        o_out_valid && o_out_data.victim_valid,
        !o_out_data.hit && !o_out_data.found_dirty)

    `TPSA_ASSERT_IMP(a_no_victim_zero, i_clk, i_rst_n,
        o_out_valid && !o_out_data.victim_valid,
        o_out_data.victim_addr == 32'd0 && !o_out_data.victim_dirty)

    `TPSA_ASSERT_IMP(a_dirty_needs_hit, i_clk, i_rst_n,
        o_out_valid && o_out_data.found_dirty,
        o_out_data.hit)

    `TPSA_ASSERT_NXT(a_out_hold, i_clk,
        i_rst_n && o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data))

    `TPSA_ASSERT_NXT(a_reset_idle, i_clk, !i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind tree_plru_set_assoc_tag_array tpsa_checker u_tpsa_checker (.*);
